>>> rtl/core/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants shared by the multidrop frame receiver modules.
// ----------------------------------------------------------------------------
package mfr_pkg;

   localparam logic [7:0] ESC_BYTE      = 8'hFF;
   localparam logic [7:0] ESC_ADDR_MARK = 8'h00;
   localparam logic [7:0] STX_BYTE      = 8'h02;
   localparam logic [7:0] ETX_BYTE      = 8'h03;
   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h41;
   localparam logic [7:0] GROUP_ADDR_RESET = 8'h40;

   localparam logic CSR_SLAVE_ADDR = 1'b0;
   localparam logic CSR_GROUP_ADDR = 1'b1;

   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_ADDR      = 3'd1;
   localparam logic [2:0] STATUS_BAD_STX   = 3'd2;
   localparam logic [2:0] STATUS_BAD_ETX   = 3'd3;
   localparam logic [2:0] STATUS_BAD_SUM   = 3'd4;
   localparam logic [2:0] STATUS_READ_ERR  = 3'd5;

   typedef enum logic [1:0] {
      ESC_NORMAL   = 2'd0,
      ESC_AFTER_FF = 2'd1,
      ESC_AFTER_00 = 2'd2
   } esc_phase_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_FUNC = 3'd2,
      PH_STX  = 3'd3,
      PH_DATA = 3'd4,
      PH_ETX  = 3'd5,
      PH_SUM  = 3'd6
   } frame_phase_type;

   typedef enum logic [1:0] {
      SYM_NONE = 2'd0,
      SYM_DATA = 2'd1,
      SYM_ADDR = 2'd2,
      SYM_ERR  = 2'd3
   } sym_kind_type;

   typedef struct packed {
      sym_kind_type kind;
      logic [7:0]   value;
   } symbol_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic [7:0] byte_index;
      logic [7:0] func_code;
      logic [7:0] frame_length;
      logic [2:0] frame_status;
   } result_type;

endpackage

>>> rtl/core/multidrop_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// multidrop_frame_receiver_unit
// Receives an escaped multidrop byte stream, frames it and emits data bytes
// and a frame-end status item.
//
//   Channel  Direction  tdata (low bit up)                         tuser
//   req_     in         rx_byte[7:0]                               read_error
//   rsp_     out        byte_value, byte_index, func_code,         result_kind
//                       frame_length, frame_status, 5 zero bits
//   csr_     in         index 0 slave_address, 1 group_address     -
//
// Each item is processed as it is taken; a new item can be taken every cycle while req_tready is high.
// An item that produces a result shows it on rsp_ the cycle after it is taken.
// The output register holds a result under stall; req_tready is low only while
// it is full and rsp_tready is low.
// Reset is synchronous: the block hunts for an address, with no escape pending.
// ----------------------------------------------------------------------------
module multidrop_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic        req_tuser,   // read_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // byte_value, byte_index, func_code,
                                    // frame_length, frame_status[34:32]
   output logic        rsp_tuser,   // result_kind
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                     req_fire;
   mfr_pkg::symbol_type      sym;
   logic                     sym_is_addr;
   logic                     addr_match;

   logic [7:0]               slave_addr_ff;
   logic [7:0]               group_addr_ff;

   mfr_pkg::frame_phase_type frame_phase_ff;
   mfr_pkg::frame_phase_type frame_phase_in;
   logic [7:0]               remaining_ff;
   logic [7:0]               remaining_in;
   logic [7:0]               position_ff;
   logic [7:0]               position_in;
   logic [7:0]               sum_ff;
   logic [7:0]               sum_in;
   logic [7:0]               func_ff;
   logic [7:0]               func_in;

   logic                     res_valid;
   mfr_pkg::result_type      res;
   logic                     res_is_end;
   logic [2:0]               res_status;

   logic                     rsp_tvalid_ff;
   logic                     rsp_tvalid_in;
   mfr_pkg::result_type      rsp_res_ff;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   mfr_escape_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .rx_byte    (req_tdata),
      .read_error (req_tuser),
      .symbol     (sym)
   );

   assign sym_is_addr = (sym.kind == mfr_pkg::SYM_ADDR);
   assign addr_match  = sym_is_addr &&
                        (sym.value == slave_addr_ff || sym.value == group_addr_ff);

   // Next state of the frame parser.
   always_comb begin
      frame_phase_in = frame_phase_ff;
      remaining_in   = remaining_ff;
      position_in    = position_ff;
      sum_in         = sum_ff;
      func_in        = func_ff;
      res_valid      = 1'b0;
      res_is_end     = 1'b0;
      res_status     = mfr_pkg::STATUS_OK;
      if (sym.kind != mfr_pkg::SYM_NONE) begin
         if (frame_phase_ff == mfr_pkg::PH_HUNT) begin
            if (addr_match) begin
               frame_phase_in = mfr_pkg::PH_LEN;
               remaining_in   = '0;
               position_in    = '0;
               sum_in         = '0;
               func_in        = '0;
            end
         end else if (sym.kind == mfr_pkg::SYM_ERR) begin
            res_is_end = 1'b1;
            res_status = mfr_pkg::STATUS_READ_ERR;
         end else begin
            unique case (frame_phase_ff)
               mfr_pkg::PH_LEN: begin
                  if (sym_is_addr) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_ADDR;
                  end else begin
                     remaining_in   = sym.value;
                     frame_phase_in = mfr_pkg::PH_FUNC;
                  end
               end
               mfr_pkg::PH_FUNC: begin
                  if (sym_is_addr) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_ADDR;
                  end else begin
                     func_in        = sym.value;
                     sum_in         = sym.value;
                     frame_phase_in = mfr_pkg::PH_STX;
                  end
               end
               mfr_pkg::PH_STX: begin
                  if (sym.value != mfr_pkg::STX_BYTE) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_BAD_STX;
                  end else if (sym_is_addr) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_ADDR;
                  end else begin
                     sum_in         = sum_ff + mfr_pkg::STX_BYTE;
                     frame_phase_in = (remaining_ff == '0) ? mfr_pkg::PH_ETX
                                                           : mfr_pkg::PH_DATA;
                  end
               end
               mfr_pkg::PH_DATA: begin
                  if (sym_is_addr) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_ADDR;
                  end else begin
                     res_valid    = 1'b1;
                     sum_in       = sum_ff + sym.value;
                     position_in  = position_ff + 8'd1;
                     remaining_in = remaining_ff - 8'd1;
                     if (remaining_ff == 8'd1) begin
                        frame_phase_in = mfr_pkg::PH_ETX;
                     end
                  end
               end
               mfr_pkg::PH_ETX: begin
                  if (sym.value != mfr_pkg::ETX_BYTE) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_BAD_ETX;
                  end else if (sym_is_addr) begin
                     res_is_end = 1'b1;
                     res_status = mfr_pkg::STATUS_ADDR;
                  end else begin
                     sum_in         = sum_ff + mfr_pkg::ETX_BYTE;
                     frame_phase_in = mfr_pkg::PH_SUM;
                  end
               end
               mfr_pkg::PH_SUM: begin
                  res_is_end = 1'b1;
                  if (sym.value != sum_ff) begin
                     res_status = mfr_pkg::STATUS_BAD_SUM;
                  end else if (sym_is_addr) begin
                     res_status = mfr_pkg::STATUS_ADDR;
                  end else begin
                     res_status = mfr_pkg::STATUS_OK;
                  end
               end
               default: begin
                  frame_phase_in = mfr_pkg::PH_HUNT;
               end
            endcase
         end
         if (res_is_end) begin
            res_valid      = 1'b1;
            frame_phase_in = mfr_pkg::PH_HUNT;
         end
      end
   end

   // Result fields.
   always_comb begin
      res.kind         = res_is_end ? mfr_pkg::KIND_FRAME_END : mfr_pkg::KIND_DATA;
      res.byte_value   = res_is_end ? 8'd0 : sym.value;
      res.byte_index   = position_ff;
      res.func_code    = func_ff;
      res.frame_length = position_ff + remaining_ff;
      res.frame_status = res_status;
   end

   assign rsp_tvalid_in = req_fire ? res_valid : (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff  <= mfr_pkg::SLAVE_ADDR_RESET;
         group_addr_ff  <= mfr_pkg::GROUP_ADDR_RESET;
         frame_phase_ff <= mfr_pkg::PH_HUNT;
         remaining_ff   <= '0;
         position_ff    <= '0;
         sum_ff         <= '0;
         func_ff        <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mfr_pkg::CSR_SLAVE_ADDR: slave_addr_ff <= csr_wdata;
               mfr_pkg::CSR_GROUP_ADDR: group_addr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire) begin
            frame_phase_ff <= frame_phase_in;
            remaining_ff   <= remaining_in;
            position_ff    <= position_in;
            sum_ff         <= sum_in;
            func_ff        <= func_in;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tdata  = {5'd0, rsp_res_ff.frame_status, rsp_res_ff.frame_length,
                        rsp_res_ff.func_code, rsp_res_ff.byte_index,
                        rsp_res_ff.byte_value};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff)
      else $error("output register not empty after reset");

   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && frame_phase_ff == mfr_pkg::PH_HUNT |-> !res_valid)
      else $error("result produced while hunting for an address");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_res_ff.kind == mfr_pkg::KIND_DATA |->
         rsp_res_ff.frame_status == mfr_pkg::STATUS_OK &&
         rsp_res_ff.byte_index < rsp_res_ff.frame_length)
      else $error("data item with bad status or index beyond frame length");

   a_end_to_hunt: assert property (@(posedge clock) disable iff (reset)
      req_fire && res_valid && res_is_end |=> frame_phase_ff == mfr_pkg::PH_HUNT)
      else $error("parser did not return to hunting after a frame end");

endmodule

>>> rtl/core/mfr_escape_decode.sv
// ----------------------------------------------------------------------------
// mfr_escape_decode
// Turns raw received bytes into data, address or error symbols.
// ----------------------------------------------------------------------------
module mfr_escape_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic                read_error,
   output mfr_pkg::symbol_type symbol
);

   mfr_pkg::esc_phase_type esc_phase_ff;
   mfr_pkg::esc_phase_type esc_phase_in;

   always_comb begin
      symbol.value = rx_byte;
      symbol.kind  = mfr_pkg::SYM_DATA;
      esc_phase_in = mfr_pkg::ESC_NORMAL;
      if (read_error) begin
         symbol.kind = mfr_pkg::SYM_ERR;
      end else begin
         unique case (esc_phase_ff)
            mfr_pkg::ESC_AFTER_FF: begin
               if (rx_byte == mfr_pkg::ESC_BYTE) begin
                  symbol.kind = mfr_pkg::SYM_DATA;
               end else if (rx_byte == mfr_pkg::ESC_ADDR_MARK) begin
                  symbol.kind  = mfr_pkg::SYM_NONE;
                  esc_phase_in = mfr_pkg::ESC_AFTER_00;
               end else begin
                  symbol.kind = mfr_pkg::SYM_ERR;
               end
            end
            mfr_pkg::ESC_AFTER_00: begin
               symbol.kind = mfr_pkg::SYM_ADDR;
            end
            default: begin
               if (rx_byte == mfr_pkg::ESC_BYTE) begin
                  symbol.kind  = mfr_pkg::SYM_NONE;
                  esc_phase_in = mfr_pkg::ESC_AFTER_FF;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_phase_ff <= mfr_pkg::ESC_NORMAL;
      end else if (accept) begin
         esc_phase_ff <= esc_phase_in;
      end
   end

   a_addr_after_mark: assert property (@(posedge clock) disable iff (reset)
      symbol.kind == mfr_pkg::SYM_ADDR |-> esc_phase_ff == mfr_pkg::ESC_AFTER_00)
      else $error("address symbol without a preceding escape mark");

   a_no_double_escape: assert property (@(posedge clock) disable iff (reset)
      accept && esc_phase_ff == mfr_pkg::ESC_AFTER_FF |=> esc_phase_ff != mfr_pkg::ESC_AFTER_FF)
      else $error("escape phase stayed after a second escape byte");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      accept && read_error |=> esc_phase_ff == mfr_pkg::ESC_NORMAL)
      else $error("read error did not clear the escape phase");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the multidrop frame receiver. Escaped byte streams are
// built from whole frames, broken frames and noise, sent with random gaps, and
// every result item is checked field by field against a predictor kept
// alongside the block. The address registers are changed between phases, and
// the result side stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_BAD_STX,
      FRAME_BAD_ETX,
      FRAME_BAD_SUM,
      FRAME_STRAY_ADDR,
      FRAME_READ_FAIL
   } frame_fault_type;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_index = mfr_pkg::CSR_SLAVE_ADDR;
   logic [7:0]  csr_wdata = 8'h00;

   mfr_pkg::result_type predicted_results[$];
   int         mismatches = 0;
   int         bytes_sent = 0;
   int         cycle_count = 0;
   int         long_hold = 0;
   bit         req_idle = 1'b1;
   bit         rsp_idle = 1'b1;

   mfr_pkg::esc_phase_type   esc_state = mfr_pkg::ESC_NORMAL;
   mfr_pkg::frame_phase_type phase_state = mfr_pkg::PH_HUNT;
   logic [7:0]      bytes_left = 8'h00;
   logic [7:0]      bytes_seen = 8'h00;
   logic [7:0]      checksum = 8'h00;
   logic [7:0]      func_seen = 8'h00;
   logic [7:0]      own_addr = mfr_pkg::SLAVE_ADDR_RESET;
   logic [7:0]      group_addr = mfr_pkg::GROUP_ADDR_RESET;

   multidrop_frame_receiver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic push_result(input logic kind, input logic [7:0] value,
                              input logic [2:0] status);
      mfr_pkg::result_type r;
      r.kind = kind;
      r.byte_value = value;
      r.byte_index = bytes_seen;
      r.func_code = func_seen;
      r.frame_length = bytes_seen + bytes_left;
      r.frame_status = status;
      predicted_results.push_back(r);
   endtask

   task automatic close_frame(input logic [2:0] status);
      push_result(mfr_pkg::KIND_FRAME_END, 8'h00, status);
      phase_state = mfr_pkg::PH_HUNT;
   endtask

   task automatic predict_frame_output(input logic [7:0] raw, input logic read_fail);
      mfr_pkg::sym_kind_type sym;
      logic         is_addr;
      sym = mfr_pkg::SYM_NONE;
      if (read_fail) begin
         esc_state = mfr_pkg::ESC_NORMAL;
         sym = mfr_pkg::SYM_ERR;
      end else begin
         case (esc_state)
            mfr_pkg::ESC_AFTER_FF: begin
               esc_state = mfr_pkg::ESC_NORMAL;
               if (raw == mfr_pkg::ESC_BYTE) sym = mfr_pkg::SYM_DATA;
               else if (raw == mfr_pkg::ESC_ADDR_MARK) esc_state = mfr_pkg::ESC_AFTER_00;
               else sym = mfr_pkg::SYM_ERR;
            end
            mfr_pkg::ESC_AFTER_00: begin
               esc_state = mfr_pkg::ESC_NORMAL;
               sym = mfr_pkg::SYM_ADDR;
            end
            default: begin
               if (raw == mfr_pkg::ESC_BYTE) esc_state = mfr_pkg::ESC_AFTER_FF;
               else sym = mfr_pkg::SYM_DATA;
            end
         endcase
      end
      if (sym == mfr_pkg::SYM_NONE) return;
      is_addr = (sym == mfr_pkg::SYM_ADDR);
      if (phase_state == mfr_pkg::PH_HUNT) begin
         if (is_addr && (raw == own_addr || raw == group_addr)) begin
            phase_state = mfr_pkg::PH_LEN;
            bytes_left = 8'h00;
            bytes_seen = 8'h00;
            checksum = 8'h00;
            func_seen = 8'h00;
         end
         return;
      end
      if (sym == mfr_pkg::SYM_ERR) begin
         close_frame(mfr_pkg::STATUS_READ_ERR);
         return;
      end
      case (phase_state)
         mfr_pkg::PH_LEN: begin
            if (is_addr) close_frame(mfr_pkg::STATUS_ADDR);
            else begin
               bytes_left = raw;
               phase_state = mfr_pkg::PH_FUNC;
            end
         end
         mfr_pkg::PH_FUNC: begin
            if (is_addr) close_frame(mfr_pkg::STATUS_ADDR);
            else begin
               func_seen = raw;
               checksum = raw;
               phase_state = mfr_pkg::PH_STX;
            end
         end
         mfr_pkg::PH_STX: begin
            if (raw != mfr_pkg::STX_BYTE) close_frame(mfr_pkg::STATUS_BAD_STX);
            else if (is_addr) close_frame(mfr_pkg::STATUS_ADDR);
            else begin
               checksum = checksum + mfr_pkg::STX_BYTE;
               phase_state = (bytes_left == 8'h00) ? mfr_pkg::PH_ETX : mfr_pkg::PH_DATA;
            end
         end
         mfr_pkg::PH_DATA: begin
            if (is_addr) close_frame(mfr_pkg::STATUS_ADDR);
            else begin
               checksum = checksum + raw;
               push_result(mfr_pkg::KIND_DATA, raw, mfr_pkg::STATUS_OK);
               bytes_seen = bytes_seen + 8'h01;
               bytes_left = bytes_left - 8'h01;
               if (bytes_left == 8'h00) phase_state = mfr_pkg::PH_ETX;
            end
         end
         mfr_pkg::PH_ETX: begin
            if (raw != mfr_pkg::ETX_BYTE) close_frame(mfr_pkg::STATUS_BAD_ETX);
            else if (is_addr) close_frame(mfr_pkg::STATUS_ADDR);
            else begin
               checksum = checksum + mfr_pkg::ETX_BYTE;
               phase_state = mfr_pkg::PH_SUM;
            end
         end
         default: begin
            if (raw != checksum) close_frame(mfr_pkg::STATUS_BAD_SUM);
            else if (is_addr) close_frame(mfr_pkg::STATUS_ADDR);
            else close_frame(mfr_pkg::STATUS_OK);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) predict_frame_output(req_tdata, req_tuser);
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      mfr_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_results.size() == 0) begin
            $display("%0t: unexpected item expected none actual kind %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = predicted_results.pop_front();
            check_field("result_kind", 8'(want.kind), 8'(rsp_tuser));
            check_field("byte_value", want.byte_value, rsp_tdata[7:0]);
            check_field("byte_index", want.byte_index, rsp_tdata[15:8]);
            check_field("func_code", want.func_code, rsp_tdata[23:16]);
            check_field("frame_length", want.frame_length, rsp_tdata[31:24]);
            check_field("frame_status", 8'(want.frame_status), 8'(rsp_tdata[34:32]));
         end
      end
   end

   initial begin
      int pause;
      wait (!reset);
      forever begin
         pause = rsp_idle ? $urandom_range(0, 4) : 0;
         pause += long_hold;
         long_hold = 0;
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_item(input logic [7:0] raw, input logic read_fail);
      int gap;
      gap = req_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= raw;
      req_tuser <= read_fail;
      bytes_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_symbol(input mfr_pkg::symbol_type s);
      case (s.kind)
         mfr_pkg::SYM_DATA: begin
            if (s.value == mfr_pkg::ESC_BYTE) send_item(mfr_pkg::ESC_BYTE, 1'b0);
            send_item(s.value, 1'b0);
         end
         mfr_pkg::SYM_ADDR: begin
            send_item(mfr_pkg::ESC_BYTE, 1'b0);
            send_item(mfr_pkg::ESC_ADDR_MARK, 1'b0);
            send_item(s.value, 1'b0);
         end
         mfr_pkg::SYM_ERR: begin
            if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
            else begin
               send_item(mfr_pkg::ESC_BYTE, 1'b0);
               send_item(8'($urandom_range(1, 254)), 1'b0);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_frame(input logic [7:0] station, input int len,
                             input logic [7:0] func, input frame_fault_type fault,
                             input int at);
      mfr_pkg::symbol_type syms[$];
      logic [7:0] sum;
      logic [7:0] value;
      int         spot;
      syms.push_back('{kind: mfr_pkg::SYM_ADDR, value: station});
      syms.push_back('{kind: mfr_pkg::SYM_DATA, value: len[7:0]});
      syms.push_back('{kind: mfr_pkg::SYM_DATA, value: func});
      syms.push_back('{kind: mfr_pkg::SYM_DATA, value: mfr_pkg::STX_BYTE});
      sum = func + mfr_pkg::STX_BYTE;
      for (int i = 0; i < len; i++) begin
         value = 8'($urandom_range(0, 255));
         sum += value;
         syms.push_back('{kind: mfr_pkg::SYM_DATA, value: value});
      end
      sum += mfr_pkg::ETX_BYTE;
      syms.push_back('{kind: mfr_pkg::SYM_DATA, value: mfr_pkg::ETX_BYTE});
      syms.push_back('{kind: mfr_pkg::SYM_DATA, value: sum});
      spot = (at >= 1) ? at : $urandom_range(1, 5 + len);
      case (fault)
         FRAME_BAD_STX: syms[3].value ^= 8'($urandom_range(1, 255));
         FRAME_BAD_ETX: syms[4 + len].value ^= 8'($urandom_range(1, 255));
         FRAME_BAD_SUM: syms[5 + len].value ^= 8'($urandom_range(1, 255));
         FRAME_STRAY_ADDR: syms[spot].kind = mfr_pkg::SYM_ADDR;
         FRAME_READ_FAIL: syms[spot].kind = mfr_pkg::SYM_ERR;
         default: ;
      endcase
      foreach (syms[i]) send_symbol(syms[i]);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == mfr_pkg::CSR_SLAVE_ADDR) own_addr = value;
      else group_addr = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_escape_edges();
      send_item(mfr_pkg::ESC_BYTE, 1'b0);
      send_item(8'h5A, 1'b1);
      send_item(mfr_pkg::ESC_BYTE, 1'b0);
      send_item(mfr_pkg::ESC_ADDR_MARK, 1'b0);
      send_item(8'hA5, 1'b1);
      send_item(mfr_pkg::ESC_BYTE, 1'b0);
      send_item(8'h7E, 1'b0);
      send_symbol('{kind: mfr_pkg::SYM_ADDR, value: mfr_pkg::SLAVE_ADDR_RESET});
      send_item(mfr_pkg::ESC_BYTE, 1'b0);
      send_item(mfr_pkg::ESC_ADDR_MARK, 1'b1);
      settle();
   endtask

   task automatic test_zero_length_frame();
      send_frame(mfr_pkg::GROUP_ADDR_RESET, 0, 8'hFF, FRAME_CLEAN, 0);
      settle();
   endtask

   task automatic test_address_inside_frame();
      send_frame(mfr_pkg::SLAVE_ADDR_RESET, 1, 8'h00, FRAME_STRAY_ADDR, 5);
      settle();
   endtask

   task automatic test_longest_frame(input logic [7:0] station);
      send_frame(station, 255, 8'($urandom_range(0, 255)), FRAME_CLEAN, 0);
      settle();
   endtask

   task automatic test_output_stall();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      long_hold = 80;
      send_frame(own_addr, 40, 8'($urandom_range(0, 255)), FRAME_CLEAN, 0);
      settle();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   task automatic test_random_traffic(input logic [7:0] slave_value,
                                      input logic [7:0] group_value, input int amount);
      int              stop_at;
      int              pick;
      int              len;
      logic [7:0]      station;
      frame_fault_type fault;
      write_reg(mfr_pkg::CSR_SLAVE_ADDR, slave_value);
      write_reg(mfr_pkg::CSR_GROUP_ADDR, group_value);
      stop_at = bytes_sent + amount;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) req_idle = !req_idle;
         if ($urandom_range(0, 9) == 0) rsp_idle = !rsp_idle;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         end else begin
            pick = $urandom_range(0, 9);
            station = (pick < 5) ? own_addr : (pick < 8) ? group_addr
                                            : 8'($urandom_range(0, 255));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
            fault = ($urandom_range(0, 9) < 6) ? FRAME_CLEAN
                                               : frame_fault_type'($urandom_range(1, 5));
            send_frame(station, len, 8'($urandom_range(0, 255)), fault, 0);
         end
      end
      settle();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   initial begin
      logic [7:0] shared_addr;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escape_edges();
      test_zero_length_frame();
      test_address_inside_frame();
      test_random_traffic(8'h00, 8'hFF, 60);
      test_random_traffic(8'hFF, 8'h00, 60);
      test_longest_frame(8'hFF);
      test_random_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 60);
      test_output_stall();
      shared_addr = 8'($urandom_range(0, 255));
      test_random_traffic(shared_addr, shared_addr, 60);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

>>> files.f
rtl/core/mfr_pkg.sv
rtl/core/mfr_escape_decode.sv
rtl/core/multidrop_frame_receiver_unit.sv
test/tb.sv
